>>> design/control_char_unescape_top_defines.svh
// Assertion macros for the control character unescape block.
// Used by the checker; expects clk and rst_n in the scope of each use.
`ifndef CONTROL_CHAR_UNESCAPE_TOP_DEFINES_SVH
`define CONTROL_CHAR_UNESCAPE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define CCEU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("control_char_unescape: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define CCEU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("control_char_unescape: next-cycle check failed");

`endif

>>> design/cceu_pkg.sv
// Shared types and constants of the control character unescape block.
// No dependencies; used by the decoder and the top level.
`default_nettype none

package cceu_pkg;

    // Decoder modes
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_CARET  = 3'd1,
        MODE_BSLASH = 3'd2,
        MODE_HEX0   = 3'd3,
        MODE_HEX1   = 3'd4,
        MODE_TRAIL  = 3'd5
    } mode_t;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DBCS_ENABLE = 2'd0,
        CFG_LEAD_LOW    = 2'd1,
        CFG_LEAD_HIGH   = 2'd2
    } cfg_index_t;

    // Register reset values
    localparam logic       DBCS_ENABLE_RST = 1'b1;
    localparam logic [7:0] LEAD_LOW_RST    = 8'd129;
    localparam logic [7:0] LEAD_HIGH_RST   = 8'd254;

    // Default depth of the result queue
    localparam int FIFO_DEPTH = 4;

    // Character codes
    localparam logic [7:0] CHAR_CARET    = 8'h5E;
    localparam logic [7:0] CHAR_AT       = 8'h40;
    localparam logic [7:0] CHAR_BACKTICK = 8'h60;
    localparam logic [7:0] CHAR_BSLASH   = 8'h5C;
    localparam logic [7:0] CHAR_UPPER_X  = 8'h58;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_NINE     = 8'h39;
    localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;
    localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;   // 'A' - 10

    // Configuration seen by the decoder
    typedef struct packed {
        logic       dbcs_enable;
        logic [7:0] lead_low;
        logic [7:0] lead_high;
    } cfg_t;

    // One result item
    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
    } result_t;

    // Decoder outcome for one input byte
    typedef struct packed {
        result_t    res0;
        result_t    res1;
        logic [1:0] count;
        mode_t      mode_next;
        logic [7:0] hex_next;
    } decode_t;

endpackage

`default_nettype wire

>>> design/cceu_decode.sv
// Combinational decode of one text byte against the current mode.
// Depends on cceu_pkg for modes, config and result types.
`default_nettype none

module cceu_decode (
    input  var cceu_pkg::mode_t   mode,
    input  var logic [7:0]        first_hex,
    input  var logic [7:0]        text_byte,
    input  var logic              final_byte,
    input  var cceu_pkg::cfg_t    cfg,
    output cceu_pkg::decode_t     dec
);

    // Upper-case a..z only
    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= cceu_pkg::CHAR_LOWER_A && c <= cceu_pkg::CHAR_LOWER_Z)
        begin
            r = c - cceu_pkg::CASE_OFFSET;
        end
        return r;
    endfunction

    // Hex digit value, wrapping modulo 256 for non-digits
    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] r;
        if (c >= cceu_pkg::CHAR_ZERO && c <= cceu_pkg::CHAR_NINE)
        begin
            r = c - cceu_pkg::CHAR_ZERO;
        end
        else
        begin
            r = upcase(c) - cceu_pkg::HEX_ALPHA_OFS;
        end
        return r;
    endfunction

    logic                is_lead;
    logic                norm_emit;
    cceu_pkg::mode_t     norm_mode;
    logic [7:0]          caret_byte;
    logic [7:0]          hex_byte;
    logic [7:0]          hi_val;
    logic [7:0]          lo_val;

    // Decode of a byte that starts a new item
    always_comb
    begin
        is_lead = cfg.dbcs_enable && (text_byte >= cfg.lead_low)
                  && (text_byte <= cfg.lead_high);
        if (text_byte == cceu_pkg::CHAR_CARET)
        begin
            norm_emit = final_byte;
            norm_mode = final_byte ? cceu_pkg::MODE_NORMAL : cceu_pkg::MODE_CARET;
        end
        else if (text_byte == cceu_pkg::CHAR_BSLASH)
        begin
            norm_emit = final_byte;
            norm_mode = final_byte ? cceu_pkg::MODE_NORMAL : cceu_pkg::MODE_BSLASH;
        end
        else
        begin
            norm_emit = 1'b1;
            norm_mode = (is_lead && !final_byte) ? cceu_pkg::MODE_TRAIL
                                                 : cceu_pkg::MODE_NORMAL;
        end
    end

    // Caret and hex values
    always_comb
    begin
        if (text_byte != cceu_pkg::CHAR_CARET && text_byte >= cceu_pkg::CHAR_AT
            && text_byte < cceu_pkg::CHAR_BACKTICK)
        begin
            caret_byte = text_byte - cceu_pkg::CHAR_AT;
        end
        else
        begin
            caret_byte = cceu_pkg::CHAR_CARET;
        end
        hi_val   = hex_value(first_hex);
        lo_val   = hex_value(text_byte);
        hex_byte = {hi_val[3:0], 4'b0000} + lo_val;
    end

    // Produce results and next state
    always_comb
    begin
        dec           = '0;
        dec.mode_next = mode;
        dec.hex_next  = first_hex;
        unique case (mode)
            cceu_pkg::MODE_CARET:
            begin
                dec.res0      = '{data: caret_byte, present: 1'b1, last: 1'b0};
                dec.count     = 2'd1;
                dec.mode_next = cceu_pkg::MODE_NORMAL;
            end
            cceu_pkg::MODE_BSLASH:
            begin
                if (upcase(text_byte) == cceu_pkg::CHAR_UPPER_X)
                begin
                    if (final_byte)
                    begin
                        dec.count = 2'd1;
                    end
                    else
                    begin
                        dec.mode_next = cceu_pkg::MODE_HEX0;
                    end
                end
                else
                begin
                    dec.res0      = '{data: cceu_pkg::CHAR_BSLASH, present: 1'b1, last: 1'b0};
                    dec.res1      = '{data: text_byte, present: 1'b1, last: 1'b0};
                    dec.count     = norm_emit ? 2'd2 : 2'd1;
                    dec.mode_next = norm_mode;
                end
            end
            cceu_pkg::MODE_HEX0:
            begin
                if (final_byte)
                begin
                    dec.res0      = '{data: text_byte, present: 1'b1, last: 1'b0};
                    dec.count     = 2'd1;
                    dec.mode_next = cceu_pkg::MODE_NORMAL;
                end
                else
                begin
                    dec.hex_next  = text_byte;
                    dec.mode_next = cceu_pkg::MODE_HEX1;
                end
            end
            cceu_pkg::MODE_HEX1:
            begin
                dec.res0      = '{data: hex_byte, present: 1'b1, last: 1'b0};
                dec.count     = 2'd1;
                dec.mode_next = cceu_pkg::MODE_NORMAL;
            end
            cceu_pkg::MODE_TRAIL:
            begin
                dec.res0      = '{data: text_byte, present: 1'b1, last: 1'b0};
                dec.count     = 2'd1;
                dec.mode_next = cceu_pkg::MODE_NORMAL;
            end
            default:
            begin
                if (norm_emit)
                begin
                    dec.res0  = '{data: text_byte, present: 1'b1, last: 1'b0};
                    dec.count = 2'd1;
                end
                dec.mode_next = norm_mode;
            end
        endcase

        // Close the text: add an end marker if nothing came out, flag the last result
        if (final_byte)
        begin
            if (dec.count == 2'd0)
            begin
                dec.res0  = '0;
                dec.count = 2'd1;
            end
            if (dec.count == 2'd2)
            begin
                dec.res1.last = 1'b1;
            end
            else
            begin
                dec.res0.last = 1'b1;
            end
            dec.mode_next = cceu_pkg::MODE_NORMAL;
            dec.hex_next  = '0;
        end
    end

endmodule

`default_nettype wire

>>> design/control_char_unescape_top.sv
// Top level of the control character unescape block: input register,
// decoder, result queue and configuration registers. Depends on cceu_pkg, cceu_decode.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_ready  | text_byte, final_byte
//   out     | out_valid / out_ready| decoded_byte, byte_present, end_of_text
//   cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One input byte is taken per cycle while the queue has room; each gives zero, one
// or two results, and the output side delivers one result per cycle while out_ready
// is high, so the sustained rate is one item per cycle when each item yields at most
// one result. A request waits in the input register until the queue has room for two
// entries. Reset clears mode, input valid and queue pointers; config gets reset values.
`default_nettype none

module control_char_unescape_top #(
    parameter int DEPTH = cceu_pkg::FIFO_DEPTH
) (
    input  var logic                          clk,
    input  var logic                          rst_n,
    input  var logic                          in_valid,
    output logic                              in_ready,
    input  var logic [7:0]                    text_byte,
    input  var logic                          final_byte,
    output logic                              out_valid,
    input  var logic                          out_ready,
    output logic [7:0]                        decoded_byte,
    output logic                              byte_present,
    output logic                              end_of_text,
    input  var logic                          cfg_valid,
    output logic                              cfg_ready,
    input  var logic [cceu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  var logic [7:0]                    cfg_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Advance a queue pointer with wrap
    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PW'(1);
        end
        return r;
    endfunction

    cceu_pkg::cfg_t      cfg_reg;
    cceu_pkg::mode_t     mode_reg;
    logic [7:0]          hex_reg;
    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                in_final_reg;
    cceu_pkg::result_t   q_reg [DEPTH];
    logic [PW-1:0]       wr_ptr_reg;
    logic [PW-1:0]       wr_ptr_next;
    logic [PW-1:0]       wr_ptr_inc;
    logic [PW-1:0]       rd_ptr_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    cceu_pkg::decode_t   dec;
    cceu_pkg::result_t   head;
    logic                fire;
    logic                pop;
    logic [1:0]          push;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dbcs_enable <= cceu_pkg::DBCS_ENABLE_RST;
            cfg_reg.lead_low    <= cceu_pkg::LEAD_LOW_RST;
            cfg_reg.lead_high   <= cceu_pkg::LEAD_HIGH_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cceu_pkg::cfg_index_t'(cfg_index))
                cceu_pkg::CFG_DBCS_ENABLE: cfg_reg.dbcs_enable <= cfg_data[0];
                cceu_pkg::CFG_LEAD_LOW:    cfg_reg.lead_low    <= cfg_data;
                cceu_pkg::CFG_LEAD_HIGH:   cfg_reg.lead_high   <= cfg_data;
                default:                   cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // Decode the held byte once the queue has room for two results
    assign fire     = in_valid_reg && (count_reg <= CW'(DEPTH - 2));
    assign in_ready = !in_valid_reg || fire;
    assign push     = fire ? dec.count : 2'd0;

    cceu_decode u_decode (
        .mode       (mode_reg),
        .first_hex  (hex_reg),
        .text_byte  (in_byte_reg),
        .final_byte (in_final_reg),
        .cfg        (cfg_reg),
        .dec        (dec)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg  <= text_byte;
            in_final_reg <= final_byte;
        end
    end

    // Decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= cceu_pkg::MODE_NORMAL;
            hex_reg  <= '0;
        end
        else if (fire)
        begin
            mode_reg <= dec.mode_next;
            hex_reg  <= dec.hex_next;
        end
    end

    // Queue pointer and count arithmetic
    always_comb
    begin
        wr_ptr_inc = ptr_inc(wr_ptr_reg);
        unique case (push)
            2'd1:    wr_ptr_next = wr_ptr_inc;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_inc);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    // Push results into the queue
    always_ff @(posedge clk)
    begin
        if (push != 2'd0)
        begin
            q_reg[wr_ptr_reg] <= dec.res0;
        end
        if (push == 2'd2)
        begin
            q_reg[wr_ptr_inc] <= dec.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
        end
    end

    // Present the queue head
    assign out_valid    = (count_reg != '0);
    assign pop          = out_valid && out_ready;
    assign head         = q_reg[rd_ptr_reg];
    assign decoded_byte = head.data;
    assign byte_present = head.present;
    assign end_of_text  = head.last;

endmodule

`default_nettype wire

>>> design/cceu_checker.sv
// Port-level checks of the control character unescape block, bound to the top.
// Depends on control_char_unescape_top_defines.svh for the assertion macros.
`default_nettype none

`include "control_char_unescape_top_defines.svh"

module cceu_checker (
    input var logic       clk,
    input var logic       rst_n,
    input var logic       in_ready,
    input var logic       out_valid,
    input var logic       out_ready,
    input var logic [7:0] decoded_byte,
    input var logic       byte_present,
    input var logic       end_of_text
);

    // Hold a stalled result request
    `CCEU_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(decoded_byte) && $stable(byte_present) && $stable(end_of_text))

    // A result without a byte is only the end marker, with zero data
    `CCEU_ASSERT_IMP(a_marker_only, out_valid && !byte_present, end_of_text && (decoded_byte == 8'd0))

    // Input stalls only while results are waiting
    `CCEU_ASSERT_IMP(a_stall_cause, !in_ready, out_valid)

endmodule

bind control_char_unescape_top cceu_checker u_cceu_checker (.*);

`default_nettype wire
